// ----- sv/efx_pkg.sv -----
// Package: shared constants and types of the escape framer with XOR checksum.
`timescale 1ns / 1ps
package efx_pkg;

   localparam int BYTE_W    = 8;
   localparam int BURST_MAX = 5;
   localparam int CNT_W     = $clog2(BURST_MAX + 1);
   localparam int IDX_W     = $clog2(BURST_MAX);

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam byte_type FLAG_BYTE    = 8'h7e;
   localparam byte_type ESC_BYTE     = 8'h7d;
   localparam byte_type ESC_FOR_FLAG = 8'h02;
   localparam byte_type ESC_FOR_ESC  = 8'h01;

   // Line bytes caused by one message byte, oldest in entry 0.
   typedef struct packed {
      logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
      cnt_type                          count;
      logic                             close;
   } burst_type;

endpackage

// ----- sv/efx_req_if.sv -----
// Interfaces: message byte channel and line byte channel.
`timescale 1ns / 1ps
interface efx_req_if;
   import efx_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface efx_rsp_if;
   import efx_pkg::*;
   logic     valid;
   logic     ready;
   byte_type line_byte;
   logic     frame_last;

   modport source (output valid, output line_byte, output frame_last, input ready);
   modport sink   (input valid, input line_byte, input frame_last, output ready);
endinterface

// ----- sv/escape_framer_xor_check.sv -----
// Top level: byte-stuffing frame builder with XOR checksum.
//
// Channels: req_chan carries one message byte per transaction, with
// end_of_message marking the final byte. rsp_chan carries line bytes, one
// per transaction; frame_last is high only on the closing flag 0x7e.
// A frame opens with 0x7e, each payload byte is stuffed (0x7e -> 0x7d 0x02,
// 0x7d -> 0x7d 0x01), then the stuffed XOR of the payload and 0x7e follow.
// An end mark on the first byte of a frame is ignored: the frame stays open.
//
// Path: a message byte passes the input register and then the burst register,
// from which its first line byte is offered. One message byte yields 1 to 5
// line bytes, and the output port sends one line byte per cycle while the
// receiver is ready; this output rate sets the throughput.
//
// Reset clears the frame state, the checksum and both stages. When the
// receiver stalls, the burst register holds, and one more message byte
// waits in the input register; req ready drops only once both are full.
`timescale 1ns / 1ps
module escape_framer_xor_check
   import efx_pkg::*;
(
   input logic          clock,
   input logic          reset,
   efx_req_if.sink      req_chan,
   efx_rsp_if.source    rsp_chan
);

   // Input register.
   logic     in_valid_ff, in_valid_in;
   byte_type in_data_ff,  in_data_in;
   logic     in_eom_ff,   in_eom_in;

   // Frame state.
   logic     open_ff, open_in;
   byte_type acc_ff,  acc_in;

   // Burst (result) register.
   logic [BURST_MAX-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   cnt_type  cnt_ff, cnt_in;
   logic     close_ff, close_in;

   burst_type enc_burst;
   byte_type  enc_xor;
   logic      enc_open;

   logic req_take;
   logic rsp_take;
   logic burst_free;
   logic move;

   efx_encode u_encode (
      .data_byte      (in_data_ff),
      .end_of_message (in_eom_ff),
      .frame_open     (open_ff),
      .xor_acc        (acc_ff),
      .burst          (enc_burst),
      .xor_next       (enc_xor),
      .open_next      (enc_open)
   );

   // Handshakes: the burst frees when empty or as its last byte leaves.
   assign rsp_take   = rsp_chan.valid && rsp_chan.ready;
   assign burst_free = (cnt_ff == '0) || ((cnt_ff == cnt_type'(1)) && rsp_take);
   assign move       = in_valid_ff && burst_free;
   assign req_chan.ready = !in_valid_ff || move;
   assign req_take   = req_chan.valid && req_chan.ready;

   // Input stage: load on a transaction, drop once moved into the burst.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_eom_in   = in_eom_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_chan.data_byte;
         in_eom_in   = req_chan.end_of_message;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // Frame state advances as a message byte enters the burst.
   assign open_in = move ? enc_open : open_ff;
   assign acc_in  = move ? enc_xor  : acc_ff;

   // Burst: load a new burst, or advance by one byte per output transaction.
   always_comb begin
      priority if (move) begin
         bytes_in = enc_burst.bytes;
         cnt_in   = enc_burst.count;
         close_in = enc_burst.close;
      end else if (rsp_take) begin
         bytes_in = {byte_type'(0), bytes_ff[BURST_MAX-1:1]};
         cnt_in   = cnt_ff - cnt_type'(1);
         close_in = close_ff;
      end else begin
         // hold while nothing moves
         bytes_in = bytes_ff;
         cnt_in   = cnt_ff;
         close_in = close_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         open_ff     <= 1'b0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         close_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         open_ff     <= open_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         close_ff    <= close_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_eom_ff  <= in_eom_in;
      bytes_ff   <= bytes_in;
   end

   // Output: head of the burst; the closing flag is its final byte.
   assign rsp_chan.valid      = (cnt_ff != '0);
   assign rsp_chan.line_byte  = bytes_ff[0];
   assign rsp_chan.frame_last = close_ff && (cnt_ff == cnt_type'(1));

endmodule

// ----- sv/efx_encode.sv -----
// Encoder: turns one message byte and the frame state into its burst of line bytes.
`timescale 1ns / 1ps
module efx_encode
   import efx_pkg::*;
(
   input  byte_type  data_byte,
   input  logic      end_of_message,
   input  logic      frame_open,
   input  byte_type  xor_acc,
   output burst_type burst,
   output byte_type  xor_next,
   output logic      open_next
);

   logic     first;
   logic     closing;
   byte_type checksum;
   idx_type  n;

   // Lead byte of the stuffed form; second byte is only used when stuffing.
   function automatic byte_type stuff_lead(input byte_type b);
      return (b == FLAG_BYTE || b == ESC_BYTE) ? ESC_BYTE : b;
   endfunction

   function automatic byte_type stuff_tail(input byte_type b);
      return (b == FLAG_BYTE) ? ESC_FOR_FLAG : ESC_FOR_ESC;
   endfunction

   function automatic logic needs_stuff(input byte_type b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   assign first    = !frame_open;
   assign closing  = end_of_message && frame_open;
   assign checksum = first ? data_byte : (xor_acc ^ data_byte);

   always_comb begin
      burst.bytes = '0;
      burst.close = closing;
      n           = '0;
      if (first) begin
         burst.bytes[n] = FLAG_BYTE;
         n              = n + idx_type'(1);
      end
      burst.bytes[n] = stuff_lead(data_byte);
      n              = n + idx_type'(1);
      if (needs_stuff(data_byte)) begin
         burst.bytes[n] = stuff_tail(data_byte);
         n              = n + idx_type'(1);
      end
      if (closing) begin
         burst.bytes[n] = stuff_lead(checksum);
         n              = n + idx_type'(1);
         if (needs_stuff(checksum)) begin
            burst.bytes[n] = stuff_tail(checksum);
            n              = n + idx_type'(1);
         end
         burst.bytes[n] = FLAG_BYTE;
         n              = n + idx_type'(1);
      end
      burst.count = (n == '0) ? cnt_type'(BURST_MAX) : cnt_type'(n);
   end

   assign xor_next  = closing ? '0 : checksum;
   assign open_next = !closing;

endmodule

// ----- sv/efx_checker.sv -----
// Checker: port-level properties of the framer, bound to the top level.
`timescale 1ns / 1ps
module efx_checker
   import efx_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_line_byte,
   input logic     rsp_frame_last
);

   // The frame end mark only ever rides on a flag byte.
   a_last_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_line_byte == FLAG_BYTE)
      else $error("frame_last on a non-flag byte");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // A stalled line byte holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_byte)
                                  && $stable(rsp_frame_last))
      else $error("stalled output changed");

   // After a closing flag leaves, the next byte offered cannot also close.
   a_no_double_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_last |=> !(rsp_valid && rsp_frame_last))
      else $error("two closing flags in a row");

endmodule

bind escape_framer_xor_check efx_checker u_efx_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_line_byte  (rsp_chan.line_byte),
   .rsp_frame_last (rsp_chan.frame_last)
);
